// ===== design/papk_pkg.sv =====
// shared types, constants and functions of the planar arm pose kinematics core
// used by the cordic cell, the pose tail and the top level; depends on nothing
package papk_pkg;

   // configuration knobs
   localparam int CORDIC_STEPS = 16;
   localparam int ANGLE_BITS   = 16;

   // cordic geometry
   localparam int ATAN_ENTRIES = 24;
   localparam int NUM_CELLS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_BITS    = $clog2(ATAN_ENTRIES);
   localparam int XY_BITS      = 32;
   localparam int PHASE_BITS   = 32;

   // starting x, the fixed gain constant with 30 fraction bits
   localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = 32'sd652032874;

   // keeps the top ANGLE_BITS bits of a phase
   localparam logic [PHASE_BITS-1:0] PHASE_MASK =
      ~PHASE_BITS'((64'd1 << (PHASE_BITS - ANGLE_BITS)) - 64'd1);

   // field widths
   localparam int ANGLE_W = 16;
   localparam int LEN_W   = 24;
   localparam int EXT_W   = 25;
   localparam int POS_W   = 26;
   localparam int PROD_W  = LEN_W + 1 + XY_BITS;
   localparam int SUM_W   = PROD_W + 1;
   localparam int FRAC_DROP = 30;

   localparam logic signed [POS_W-1:0] POS_MAX = 26'sd33554431;
   localparam logic signed [POS_W-1:0] POS_MIN = -26'sd33554432;

   // one rotation lane: vector and residual phase
   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic [PHASE_BITS-1:0]     z;
   } papk_lane_type;

   // word handed from cell to cell
   typedef struct packed {
      logic                      valid;
      papk_lane_type             shoulder;
      papk_lane_type             elbow;
      logic                      flip_shoulder;
      logic                      flip_elbow;
      logic [ANGLE_W-1:0]        yaw;
      logic signed [POS_W-1:0]   pos_z;
   } papk_word_type;

   // arctangent of 2^-i in phase units (2^32 per turn)
   function automatic logic [PHASE_BITS-1:0] papk_atan(input logic [STEP_BITS-1:0] idx);
      logic [PHASE_BITS-1:0] val;
      begin
         case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = '0;
         endcase
         return val;
      end
   endfunction

   // one micro-rotation, direction from the residual phase sign
   function automatic papk_lane_type papk_rotate(input papk_lane_type lane,
                                                 input logic [STEP_BITS-1:0] step);
      logic signed [XY_BITS-1:0] xs;
      logic signed [XY_BITS-1:0] ys;
      papk_lane_type             res;
      begin
         xs = lane.x >>> step;
         ys = lane.y >>> step;
         if (lane.z[PHASE_BITS-1]) begin
            res.x = lane.x + ys;
            res.y = lane.y - xs;
            res.z = lane.z + papk_atan(step);
         end else begin
            res.x = lane.x - ys;
            res.y = lane.y + xs;
            res.z = lane.z - papk_atan(step);
         end
         return res;
      end
   endfunction

endpackage

// ===== design/planar_arm_pose_kinematics_core.sv =====
// pipeline: an accepted word loads into the first cordic cell at the accepting edge, then moves
// through each further cordic cell and then the tail stage registers in order (trig fold, products,
// result register) before it shows on rsp_valid
// throughput: one word per cycle; the whole pipe holds while a result waits on rsp_ready
// reset: synchronous, active high; clears all stage valid bits and the three registers
// top level: joint state in, end-effector pose out, apb register port; depends on papk_pkg
module planar_arm_pose_kinematics_core
   import papk_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [ANGLE_W-1:0] req_shoulder_angle,
   input  logic signed [ANGLE_W-1:0] req_elbow_angle,
   input  logic signed [EXT_W-1:0]   req_extension,
   input  logic signed [ANGLE_W-1:0] req_wrist_angle,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [POS_W-1:0]   rsp_pos_x,
   output logic signed [POS_W-1:0]   rsp_pos_y,
   output logic signed [POS_W-1:0]   rsp_pos_z,
   output logic signed [ANGLE_W-1:0] rsp_yaw,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [3:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   // register index codes
   localparam logic [1:0] REG_UPPER_ARM = 2'd0;
   localparam logic [1:0] REG_FOREARM   = 2'd1;
   localparam logic [1:0] REG_BASE      = 2'd2;

   logic [LEN_W-1:0] upper_len_ff;
   logic [LEN_W-1:0] fore_len_ff;
   logic [LEN_W-1:0] base_height_ff;
   logic             csr_write;
   logic [1:0]       csr_index;

   logic                  enable;
   logic [ANGLE_W-1:0]    elbow_sum;
   logic [PHASE_BITS-1:0] phase_shoulder;
   logic [PHASE_BITS-1:0] phase_elbow;
   papk_word_type         first_word;
   papk_word_type         chain [NUM_CELLS];

   logic                      tail_valid;
   logic signed [POS_W-1:0]   tail_pos_x;
   logic signed [POS_W-1:0]   tail_pos_y;
   logic signed [POS_W-1:0]   tail_pos_z;
   logic [ANGLE_W-1:0]        tail_yaw;

   // apb register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_len_ff   <= '0;
         fore_len_ff    <= '0;
         base_height_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_UPPER_ARM: upper_len_ff   <= csr_pwdata[LEN_W-1:0];
            REG_FOREARM:   fore_len_ff    <= csr_pwdata[LEN_W-1:0];
            REG_BASE:      base_height_ff <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_UPPER_ARM: csr_prdata = {8'd0, upper_len_ff};
         REG_FOREARM:   csr_prdata = {8'd0, fore_len_ff};
         REG_BASE:      csr_prdata = {8'd0, base_height_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // pipe advances unless a result sits unaccepted
   assign enable    = !(rsp_valid && !rsp_ready);
   assign req_ready = enable;

   // phase setup: widen, quantize, fold the left half-plane by a half turn
   assign elbow_sum      = req_shoulder_angle + req_elbow_angle;
   assign phase_shoulder = {req_shoulder_angle, 16'd0} & PHASE_MASK;
   assign phase_elbow    = {elbow_sum, 16'd0} & PHASE_MASK;

   always_comb begin
      first_word.valid         = req_valid;
      first_word.flip_shoulder = phase_shoulder[31] ^ phase_shoulder[30];
      first_word.flip_elbow    = phase_elbow[31] ^ phase_elbow[30];
      first_word.shoulder.x    = CORDIC_GAIN;
      first_word.shoulder.y    = '0;
      first_word.shoulder.z    = {phase_shoulder[30], phase_shoulder[30:0]};
      first_word.elbow.x       = CORDIC_GAIN;
      first_word.elbow.y       = '0;
      first_word.elbow.z       = {phase_elbow[30], phase_elbow[30:0]};
      first_word.yaw           = elbow_sum + req_wrist_angle;
      first_word.pos_z         = $signed({2'b00, base_height_ff})
                                 - $signed({req_extension[EXT_W-1], req_extension});
   end

   // chain of cordic cells, one micro-rotation each
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      if (k == 0) begin : g_head
         papk_cordic_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .enable    (enable),
            .step      (STEP_BITS'(k)),
            .prev_word (first_word),
            .word_out  (chain[k])
         );
      end else begin : g_body
         papk_cordic_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .enable    (enable),
            .step      (STEP_BITS'(k)),
            .prev_word (chain[k-1]),
            .word_out  (chain[k])
         );
      end
   end

   // products, rounding and the result word register
   papk_pose_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .last_word (chain[NUM_CELLS-1]),
      .upper_len (upper_len_ff),
      .fore_len  (fore_len_ff),
      .out_valid (tail_valid),
      .out_pos_x (tail_pos_x),
      .out_pos_y (tail_pos_y),
      .out_pos_z (tail_pos_z),
      .out_yaw   (tail_yaw)
   );

   assign rsp_valid = tail_valid;
   assign rsp_pos_x = tail_pos_x;
   assign rsp_pos_y = tail_pos_y;
   assign rsp_pos_z = tail_pos_z;
   assign rsp_yaw   = $signed(tail_yaw);

`ifndef SYNTHESIS
   // a waiting result holds the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while a result is stalled");

   // an accepted word enters the first cell
   a_accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> chain[0].valid)
      else $error("accepted word missing from first cordic cell");

   // a stalled pipe keeps its last cell word
   a_stall_holds_chain: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(chain[NUM_CELLS-1]))
      else $error("cordic chain moved during a stall");

   // nothing comes out right after reset
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== design/papk_cordic_cell.sv =====
// one cordic cell: a single micro-rotation for both angle lanes, registered
// depends on papk_pkg for the word type and the rotation function
module papk_cordic_cell
   import papk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic [STEP_BITS-1:0] step,
   input  papk_word_type        prev_word,
   output papk_word_type        word_out
);

   papk_word_type cell_ff;
   papk_word_type cell_in;

   // rotate both lanes, carry the side data along
   always_comb begin
      cell_in          = prev_word;
      cell_in.shoulder = papk_rotate(prev_word.shoulder, step);
      cell_in.elbow    = papk_rotate(prev_word.elbow, step);
   end

   // stage register, moves only when the pipe advances
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in;
      end
   end

   assign word_out = cell_ff;

endmodule

// ===== design/papk_pose_tail.sv =====
// pose tail: quadrant fold-back, link products, rounding and saturation
// depends on papk_pkg; takes the last cordic cell word and the link lengths
module papk_pose_tail
   import papk_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  papk_word_type             last_word,
   input  logic [LEN_W-1:0]          upper_len,
   input  logic [LEN_W-1:0]          fore_len,
   output logic                      out_valid,
   output logic signed [POS_W-1:0]   out_pos_x,
   output logic signed [POS_W-1:0]   out_pos_y,
   output logic signed [POS_W-1:0]   out_pos_z,
   output logic [ANGLE_W-1:0]        out_yaw
);

   typedef struct packed {
      logic                      valid;
      logic signed [XY_BITS-1:0] cos1;
      logic signed [XY_BITS-1:0] sin1;
      logic signed [XY_BITS-1:0] cos12;
      logic signed [XY_BITS-1:0] sin12;
      logic [ANGLE_W-1:0]        yaw;
      logic signed [POS_W-1:0]   pos_z;
   } papk_trig_type;

   typedef struct packed {
      logic                     valid;
      logic signed [PROD_W-1:0] px1;
      logic signed [PROD_W-1:0] px2;
      logic signed [PROD_W-1:0] py1;
      logic signed [PROD_W-1:0] py2;
      logic [ANGLE_W-1:0]       yaw;
      logic signed [POS_W-1:0]  pos_z;
   } papk_prod_type;

   papk_trig_type trig_ff;
   papk_trig_type trig_in;
   papk_prod_type prod_ff;
   papk_prod_type prod_in;

   logic                    out_valid_ff;
   logic signed [POS_W-1:0] pos_x_ff;
   logic signed [POS_W-1:0] pos_x_in;
   logic signed [POS_W-1:0] pos_y_ff;
   logic signed [POS_W-1:0] pos_y_in;
   logic signed [POS_W-1:0] pos_z_ff;
   logic [ANGLE_W-1:0]      yaw_ff;

   logic signed [LEN_W:0]   upper_s;
   logic signed [LEN_W:0]   fore_s;

   // saturate a rounded sum to the position range
   function automatic logic signed [POS_W-1:0] papk_finish(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0]            rounded;
      logic signed [SUM_W-FRAC_DROP-1:0]  scaled;
      logic signed [POS_W-1:0]            res;
      begin
         rounded = sum + (SUM_W'(1) <<< (FRAC_DROP - 1));
         scaled  = rounded[SUM_W-1:FRAC_DROP];
         if (scaled > (SUM_W-FRAC_DROP)'(POS_MAX)) begin
            res = POS_MAX;
         end else if (scaled < (SUM_W-FRAC_DROP)'(POS_MIN)) begin
            res = POS_MIN;
         end else begin
            res = scaled[POS_W-1:0];
         end
         return res;
      end
   endfunction

   // fold the half-turn offset back out of the cordic results
   always_comb begin
      trig_in.valid = last_word.valid;
      trig_in.cos1  = last_word.flip_shoulder ? -last_word.shoulder.x : last_word.shoulder.x;
      trig_in.sin1  = last_word.flip_shoulder ? -last_word.shoulder.y : last_word.shoulder.y;
      trig_in.cos12 = last_word.flip_elbow ? -last_word.elbow.x : last_word.elbow.x;
      trig_in.sin12 = last_word.flip_elbow ? -last_word.elbow.y : last_word.elbow.y;
      trig_in.yaw   = last_word.yaw;
      trig_in.pos_z = last_word.pos_z;
   end

   // link length times trig, one multiplier per product
   assign upper_s = $signed({1'b0, upper_len});
   assign fore_s  = $signed({1'b0, fore_len});

   always_comb begin
      prod_in.valid = trig_ff.valid;
      prod_in.px1   = upper_s * trig_ff.cos1;
      prod_in.px2   = fore_s * trig_ff.cos12;
      prod_in.py1   = upper_s * trig_ff.sin1;
      prod_in.py2   = fore_s * trig_ff.sin12;
      prod_in.yaw   = trig_ff.yaw;
      prod_in.pos_z = trig_ff.pos_z;
   end

   // sum, round half up, saturate
   assign pos_x_in = papk_finish(SUM_W'(prod_ff.px1) + SUM_W'(prod_ff.px2));
   assign pos_y_in = papk_finish(SUM_W'(prod_ff.py1) + SUM_W'(prod_ff.py2));

   // tail stage registers, the last one is the result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff.valid <= 1'b0;
         prod_ff.valid <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (enable) begin
         trig_ff      <= trig_in;
         prod_ff      <= prod_in;
         out_valid_ff <= prod_ff.valid;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= prod_ff.pos_z;
         yaw_ff       <= prod_ff.yaw;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pos_x = pos_x_ff;
   assign out_pos_y = pos_y_ff;
   assign out_pos_z = pos_z_ff;
   assign out_yaw   = yaw_ff;

endmodule

// ===== tb/planar_arm_pose_kinematics_core_tb.sv =====
// testbench for planar_arm_pose_kinematics_core: joint states in, checked poses out
// depends on papk_pkg for field widths and step counts, and on the core itself
module planar_arm_pose_kinematics_core_tb
   import papk_pkg::*;
();

   // register map of the apb port
   typedef enum logic [1:0] {
      ARM_REG_UPPER = 2'd0,
      ARM_REG_FORE  = 2'd1,
      ARM_REG_BASE  = 2'd2,
      ARM_REG_SPARE = 2'd3
   } arm_reg_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] shoulder_angle;
      logic signed [ANGLE_W-1:0] elbow_angle;
      logic signed [EXT_W-1:0]   extension;
      logic signed [ANGLE_W-1:0] wrist_angle;
   } joint_type;

   typedef struct packed {
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic signed [ANGLE_W-1:0] yaw;
   } pose_type;

   localparam int     RESET_CYCLES    = 9;
   localparam int     SETTLE_CYCLES   = 30;
   localparam int     CYCLE_LIMIT     = 100000;
   localparam int     LONG_HOLD       = 120;
   localparam int     HOLD_AT_POSE    = 40;
   localparam int     RANDOM_PHASES   = 8;
   localparam int     ITEMS_PER_PHASE = 135;
   localparam int     REPORT_CAP      = 100;
   localparam int     ATAN_COUNT      = 24;
   localparam longint GAIN_Q30        = 64'sd652032874;
   localparam int     FRAC_SHIFT      = 30;
   localparam longint HALF_LSB        = longint'(1) <<< (FRAC_SHIFT - 1);
   localparam longint POS_HI          = (longint'(1) <<< (POS_W - 1)) - 1;
   localparam longint POS_LO          = -POS_HI - 1;

   // arctangent of 2^-i as a fraction of 2^32 per turn
   localparam logic [0:ATAN_COUNT-1][31:0] ATAN_TURN = {
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [ANGLE_W-1:0] req_shoulder_angle = '0;
   logic signed [ANGLE_W-1:0] req_elbow_angle = '0;
   logic signed [EXT_W-1:0]   req_extension = '0;
   logic signed [ANGLE_W-1:0] req_wrist_angle = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [POS_W-1:0]   rsp_pos_x;
   logic signed [POS_W-1:0]   rsp_pos_y;
   logic signed [POS_W-1:0]   rsp_pos_z;
   logic signed [ANGLE_W-1:0] rsp_yaw;

   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [3:0]                csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // shadow copy of the arm geometry registers
   logic [23:0] upper_arm_q = '0;
   logic [23:0] forearm_q = '0;
   logic [23:0] base_height_q = '0;

   joint_type joint_pending[$];
   pose_type  pose_expected[$];
   joint_type joint_offered;
   pose_type  pose_due;

   logic   idling = 1'b1;
   int     send_gap = 0;
   int     stall_left = 0;
   int     hold_left = 0;
   logic   hold_done = 1'b0;
   int     poses_seen = 0;
   int     mismatch_count = 0;
   int     cycle_count = 0;

   planar_arm_pose_kinematics_core dut (.*);

   always #1 clock = ~clock;

   // cos and sin of a binary angle, 30 fraction bits, by rotation-mode cordic
   function automatic void unit_vector(input logic [ANGLE_W-1:0] angle,
                                       output longint cos_q30, output longint sin_q30);
      logic [31:0] phase;
      logic        flip;
      longint      vx;
      longint      vy;
      longint      sx;
      longint      sy;
      phase = {angle, 16'h0000};
      if (ANGLE_BITS < 32) begin
         phase &= ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);
      end
      // left half plane: rotate by a half turn and negate at the end
      flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      if (flip) begin
         phase += 32'h8000_0000;
      end
      vx = GAIN_Q30;
      vy = 0;
      for (int n = 0; n < CORDIC_STEPS && n < ATAN_COUNT; n++) begin
         sx = vx >>> n;
         sy = vy >>> n;
         if (phase[31]) begin
            vx = vx + sy;
            vy = vy - sx;
            phase += ATAN_TURN[n];
         end else begin
            vx = vx - sy;
            vy = vy + sx;
            phase -= ATAN_TURN[n];
         end
      end
      cos_q30 = flip ? -vx : vx;
      sin_q30 = flip ? -vy : vy;
   endfunction

   // 46 fraction bits down to 16, round half up, clamp to the port range
   function automatic logic signed [POS_W-1:0] round_to_pos(input longint acc_q46);
      longint r;
      r = (acc_q46 + HALF_LSB) >>> FRAC_SHIFT;
      if (r > POS_HI) begin
         r = POS_HI;
      end else if (r < POS_LO) begin
         r = POS_LO;
      end
      return r[POS_W-1:0];
   endfunction

   // end-effector pose of one joint state under the current geometry
   function automatic pose_type predict_pose(input joint_type j);
      logic [ANGLE_W-1:0] elbow_abs;
      longint             c1;
      longint             s1;
      longint             c12;
      longint             s12;
      pose_type           p;
      elbow_abs = j.shoulder_angle + j.elbow_angle;
      unit_vector(j.shoulder_angle, c1, s1);
      unit_vector(elbow_abs, c12, s12);
      p.pos_x = round_to_pos(longint'(upper_arm_q) * c1 + longint'(forearm_q) * c12);
      p.pos_y = round_to_pos(longint'(upper_arm_q) * s1 + longint'(forearm_q) * s12);
      p.pos_z = POS_W'(longint'(base_height_q) - longint'(j.extension));
      p.yaw   = elbow_abs + j.wrist_angle;
      return p;
   endfunction

   function automatic void note_field(input string name, input logic signed [POS_W-1:0] want,
                                      input logic signed [POS_W-1:0] got);
      if (got !== want) begin
         if (mismatch_count < REPORT_CAP) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         end
         mismatch_count++;
      end
   endfunction

   function automatic void queue_joint(input logic [ANGLE_W-1:0] shoulder,
                                       input logic [ANGLE_W-1:0] elbow,
                                       input logic [EXT_W-1:0] ext,
                                       input logic [ANGLE_W-1:0] wrist);
      joint_type j;
      j.shoulder_angle = shoulder;
      j.elbow_angle    = elbow;
      j.extension      = ext;
      j.wrist_angle    = wrist;
      joint_pending.push_back(j);
   endfunction

   // angles biased toward quadrant edges and the wrap point
   function automatic logic [ANGLE_W-1:0] pick_angle();
      case ($urandom_range(0, 3))
         0, 1:    return ANGLE_W'($urandom());
         2:       return ANGLE_W'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 8) - 4);
         default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   function automatic joint_type random_joint();
      joint_type j;
      j.shoulder_angle = pick_angle();
      j.elbow_angle    = pick_angle();
      j.wrist_angle    = pick_angle();
      case ($urandom_range(0, 7))
         0:       j.extension = {1'b0, {(EXT_W-1){1'b1}}};
         1:       j.extension = {1'b1, {(EXT_W-1){1'b0}}};
         2:       j.extension = EXT_W'($urandom_range(0, 16'hFFFF)) - (EXT_W'(1) << 15);
         default: j.extension = EXT_W'($urandom());
      endcase
      return j;
   endfunction

   function automatic logic [23:0] pick_length();
      case ($urandom_range(0, 4))
         0:       return 24'hFFFFFF;
         1:       return 24'h000000;
         2:       return 24'($urandom_range(0, 24'h3FFFF));
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic csr_write(input arm_reg_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         ARM_REG_UPPER: upper_arm_q = value[23:0];
         ARM_REG_FORE:  forearm_q = value[23:0];
         ARM_REG_BASE:  base_height_q = value[23:0];
         default: ;
      endcase
   endtask

   task automatic csr_read(input arm_reg_type idx, output logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // load a geometry, poke the unmapped slot, read the three geometry registers back
   task automatic program_arm(input logic [23:0] l1, input logic [23:0] l2,
                              input logic [23:0] d1);
      logic [31:0] rd;
      logic [23:0] want;
      csr_write(ARM_REG_UPPER, {8'($urandom()), l1});
      csr_write(ARM_REG_FORE, {8'($urandom()), l2});
      csr_write(ARM_REG_SPARE, $urandom());
      csr_write(ARM_REG_BASE, {8'($urandom()), d1});
      for (int i = 0; i < 3; i++) begin
         csr_read(arm_reg_type'(i), rd);
         case (arm_reg_type'(i))
            ARM_REG_UPPER: want = upper_arm_q;
            ARM_REG_FORE:  want = forearm_q;
            default:       want = base_height_q;
         endcase
         if (rd[23:0] !== want) begin
            $error("register %0d readback mismatch: expected %0d, actual %0d",
                   i, want, rd[23:0]);
            mismatch_count++;
         end
      end
   endtask

   // wait until every queued joint state has come back as a pose
   task automatic drain();
      do @(negedge clock);
      while (joint_pending.size() != 0 || req_valid || pose_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // joint state driver with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            pose_expected.push_back(predict_pose(joint_offered));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (joint_pending.size() != 0) begin
               joint_offered = joint_pending.pop_front();
               req_shoulder_angle <= joint_offered.shoulder_angle;
               req_elbow_angle    <= joint_offered.elbow_angle;
               req_extension      <= joint_offered.extension;
               req_wrist_angle    <= joint_offered.wrist_angle;
               req_valid          <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // pose monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pose_expected.size() == 0) begin
               $error("pose word with no joint state outstanding");
               mismatch_count++;
            end else begin
               pose_due = pose_expected.pop_front();
               poses_seen++;
               note_field("pos_x", pose_due.pos_x, rsp_pos_x);
               note_field("pos_y", pose_due.pos_y, rsp_pos_y);
               note_field("pos_z", pose_due.pos_z, rsp_pos_z);
               note_field("yaw", POS_W'(pose_due.yaw), POS_W'(rsp_yaw));
            end
         end
         // one long hold-off early on so the pipe backs up into the input
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && poses_seen == HOLD_AT_POSE) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // unit geometry: quadrants, wrap of the yaw sum, extension extremes
      program_arm(24'h010000, 24'h008000, 24'h200000);
      queue_joint(16'h0000, 16'h0000, 25'h0000000, 16'h0000);
      queue_joint(16'h4000, 16'h0000, 25'h0FFFFFF, 16'h0000);
      queue_joint(16'h8000, 16'h0000, 25'h1000000, 16'h0000);
      queue_joint(16'hC000, 16'h0000, 25'h0000001, 16'h0000);
      queue_joint(16'h7FFF, 16'h7FFF, 25'h0000000, 16'h7FFF);
      queue_joint(16'h8000, 16'h8000, 25'h1FFFFFF, 16'h8000);
      queue_joint(16'h4000, 16'h4000, 25'h0000000, 16'h0000);
      queue_joint(16'h3FFF, 16'h0001, 25'h0AAAAAA, 16'h4000);
      queue_joint(16'hBFFF, 16'h0001, 25'h1555555, 16'hC000);
      queue_joint(16'h2000, 16'h2000, 25'h0010000, 16'h2000);
      queue_joint(16'hFFFF, 16'h0001, 25'h1FFFFFF, 16'hFFFF);
      queue_joint(16'h1234, 16'hEDCC, 25'h0000001, 16'h0001);
      drain();

      // longest links: positions clamp at both ends, height at its top
      program_arm(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      queue_joint(16'h0000, 16'h0000, 25'h1000000, 16'h0000);
      queue_joint(16'h8000, 16'h0000, 25'h0FFFFFF, 16'h0000);
      queue_joint(16'h4000, 16'h0000, 25'h0000000, 16'h0000);
      queue_joint(16'hC000, 16'h0000, 25'h0000000, 16'h0000);
      queue_joint(16'h2000, 16'h0000, 25'h0123456, 16'h7FFF);
      queue_joint(16'h0000, 16'h8000, 25'h1000000, 16'h8000);
      drain();

      // zero geometry: height alone, at its bottom and just past the middle
      program_arm(24'h000000, 24'h000000, 24'h000000);
      queue_joint(16'h7FFF, 16'h8000, 25'h0FFFFFF, 16'h7FFF);
      queue_joint(16'h8000, 16'h7FFF, 25'h1000000, 16'h8000);
      queue_joint(16'h5555, 16'hAAAA, 25'h0AAAAAA, 16'h5555);
      drain();

      // random geometries and joint states; the last phase runs without gaps
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idling <= (ph == 0) || ((ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0));
         program_arm(pick_length(), pick_length(), pick_length());
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            joint_pending.push_back(random_joint());
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
